[hdl/rdc_pkg.sv]
// Shared types, constants and the CRC step for the record deframer and checker.
`timescale 1ns / 1ps

package rdc_pkg;

  localparam int RECORD_BYTES = 256;
  localparam int REC_AW       = $clog2(RECORD_BYTES);
  localparam int CNT_W        = REC_AW + 1;
  localparam int RAM_AW       = REC_AW + 1;
  localparam int MIN_RECORD   = 8;

  localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_LEN_BAD   = 2'd2;
  localparam logic [1:0] ST_CRC_BAD   = 2'd3;

  localparam logic [7:0] CFG_START      = 8'd0;
  localparam logic [7:0] CFG_END        = 8'd1;
  localparam logic [7:0] CFG_ESC        = 8'd2;
  localparam logic [7:0] CFG_ESC_OFFSET = 8'd3;

  localparam logic [7:0] RST_START      = 8'd90;
  localparam logic [7:0] RST_END        = 8'd91;
  localparam logic [7:0] RST_ESC        = 8'd92;
  localparam logic [7:0] RST_ESC_OFFSET = 8'd64;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  check_status;
    logic [15:0] record_type;
    logic [8:0]  record_length;
    logic [7:0]  read_byte;
    logic        index_valid;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [RAM_AW-1:0] raddr;
  } ram_req_t;

  // One byte of CRC-16/ARC, reflected, bit at a time.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[hdl/rdc_ram.sv]
// Two-bank record byte memory: one write port, one registered read port.
`timescale 1ns / 1ps

module rdc_ram
  import rdc_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output logic [7:0] rdata
);

  logic [7:0] mem [2*RECORD_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/record_deframer_checker.sv]
// Top level of the escaped record deframer with CRC-16/ARC check.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-------------------------------
// in_      | input     | in_valid / in_stall    | in_item  (opcode, byte, index)
// out_     | output    | out_valid / out_stall  | out_item (report or read data)
// cfg_     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item is accepted per cycle while the result path is free. Every feed
// byte updates the framing state in its accept cycle; a stored byte also
// updates the CRC and makes one memory write. A read or a report passes s1,
// which waits for the registered memory read, and then the output register.
// The memory holds two banks; closing a record swaps banks, so no copy runs.
// Synchronous active-low reset clears all control state; no clearing pass.

module record_deframer_checker
  import rdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,

  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,

  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // Marker registers
  logic [7:0] start_r, end_r, esc_r, esc_off_r;

  // Framing state
  logic             in_rec_r, in_rec_nxt;
  logic             esc_pend_r, esc_pend_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      slen_r, slen_nxt;
  logic [15:0]      scrc_r, scrc_nxt;
  logic [15:0]      ftype_r, ftype_nxt;
  logic             asm_bank_r, asm_bank_nxt;
  logic             held_bank_r, held_bank_nxt;
  logic [CNT_W-1:0] held_len_r, held_len_nxt;

  // Result pipeline: s1 waits for memory data, out is the output register
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_kind_r;
  logic [1:0]  s1_status_r;
  logic [15:0] s1_type_r;
  logic [8:0]  s1_len_r;
  logic        s1_idx_ok_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r;

  logic       accept, feed, rd;
  logic       s1_advance;
  logic       do_open, do_store, do_close, do_abandon;
  logic [7:0] b, store_val;
  logic       has_result;
  logic       idx_ok;
  logic [1:0] status;
  logic [CNT_W-1:0] close_len;
  ram_req_t   ram_req;
  logic [7:0] ram_rdata;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid_r && (!out_valid_r || !out_stall);
  // Hold the input while a finished result sits in s1 and cannot move on
  assign in_stall   = s1_valid_r && !s1_advance;
  assign accept     = in_valid && !in_stall;
  assign feed       = accept && (in_item.opcode == OP_FEED);
  assign rd         = accept && (in_item.opcode == OP_READ);
  assign b          = in_item.rx_byte;
  assign idx_ok     = (16'(in_item.read_index) < 16'(held_len_r));

  always_comb begin
    in_rec_nxt    = in_rec_r;
    esc_pend_nxt  = esc_pend_r;
    fill_nxt      = fill_r;
    crc_nxt       = crc_r;
    slen_nxt      = slen_r;
    scrc_nxt      = scrc_r;
    ftype_nxt     = ftype_r;
    asm_bank_nxt  = asm_bank_r;
    held_bank_nxt = held_bank_r;
    held_len_nxt  = held_len_r;
    do_open       = 1'b0;
    do_store      = 1'b0;
    do_close      = 1'b0;
    do_abandon    = 1'b0;
    store_val     = b;
    close_len     = '0;
    status        = ST_OK;
    ram_req       = '0;

    ram_req.re    = rd;
    ram_req.raddr = {held_bank_r, REC_AW'(in_item.read_index)};

    // Decide what the fed byte does
    if (feed) begin
      if (!in_rec_r) begin
        do_open = (b == start_r);
      end else if (esc_pend_r) begin
        esc_pend_nxt = 1'b0;
        if (fill_r < CNT_W'(RECORD_BYTES)) begin
          do_store  = 1'b1;
          store_val = b - esc_off_r;
        end else begin
          do_abandon = 1'b1;
        end
      end else if (b == esc_r) begin
        esc_pend_nxt = 1'b1;
      end else if (b == start_r) begin
        do_open = 1'b1;
      end else if (fill_r >= CNT_W'(RECORD_BYTES)) begin
        do_abandon = 1'b1;
      end else begin
        do_store = 1'b1;
        do_close = (b == end_r);
      end
    end

    // Restart the record with the start byte as its first entry
    if (do_open) begin
      in_rec_nxt   = 1'b1;
      esc_pend_nxt = 1'b0;
      fill_nxt     = '0;
      crc_nxt      = '0;
      slen_nxt     = '0;
      scrc_nxt     = '0;
      ftype_nxt    = '0;
      do_store     = 1'b1;
      store_val    = start_r;
    end

    // Drop the record on overflow, keep the held one
    if (do_abandon) begin
      in_rec_nxt   = 1'b0;
      esc_pend_nxt = 1'b0;
      fill_nxt     = '0;
    end

    if (do_store) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = {asm_bank_r, fill_nxt[REC_AW-1:0]};
      ram_req.wdata = store_val;
      if (fill_nxt == CNT_W'(1)) slen_nxt[7:0]   = store_val;
      if (fill_nxt == CNT_W'(2)) slen_nxt[15:8]  = store_val;
      if (fill_nxt == CNT_W'(3)) scrc_nxt[7:0]   = store_val;
      if (fill_nxt == CNT_W'(4)) scrc_nxt[15:8]  = store_val;
      if (fill_nxt == CNT_W'(5)) ftype_nxt[7:0]  = store_val;
      if (fill_nxt == CNT_W'(6)) ftype_nxt[15:8] = store_val;
      // CRC bytes count as zero in the running CRC
      crc_nxt = crc16_step(crc_nxt,
                           (fill_nxt == CNT_W'(3) || fill_nxt == CNT_W'(4)) ? 8'h00 : store_val);
      fill_nxt = fill_nxt + CNT_W'(1);
    end

    // Close: swap banks, check, and go back to hunting
    if (do_close) begin
      close_len     = fill_nxt;
      held_bank_nxt = asm_bank_r;
      asm_bank_nxt  = ~asm_bank_r;
      held_len_nxt  = close_len;
      in_rec_nxt    = 1'b0;
      esc_pend_nxt  = 1'b0;
      fill_nxt      = '0;
      if (close_len < CNT_W'(MIN_RECORD)) begin
        status = ST_SHORT;
      end else if (slen_nxt != 16'(close_len)) begin
        status = ST_LEN_BAD;
      end else if (crc_nxt != scrc_nxt) begin
        status = ST_CRC_BAD;
      end else begin
        status = ST_OK;
      end
    end
  end

  assign has_result = rd || do_close;

  always_comb begin
    if (has_result) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (s1_advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  rdc_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= RST_START;
      end_r       <= RST_END;
      esc_r       <= RST_ESC;
      esc_off_r   <= RST_ESC_OFFSET;
      in_rec_r    <= 1'b0;
      esc_pend_r  <= 1'b0;
      fill_r      <= '0;
      crc_r       <= '0;
      slen_r      <= '0;
      scrc_r      <= '0;
      ftype_r     <= '0;
      asm_bank_r  <= 1'b0;
      held_bank_r <= 1'b1;
      held_len_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START:      start_r   <= cfg_data;
          CFG_END:        end_r     <= cfg_data;
          CFG_ESC:        esc_r     <= cfg_data;
          CFG_ESC_OFFSET: esc_off_r <= cfg_data;
          default:        ;
        endcase
      end
      in_rec_r    <= in_rec_nxt;
      esc_pend_r  <= esc_pend_nxt;
      fill_r      <= fill_nxt;
      crc_r       <= crc_nxt;
      slen_r      <= slen_nxt;
      scrc_r      <= scrc_nxt;
      ftype_r     <= ftype_nxt;
      asm_bank_r  <= asm_bank_nxt;
      held_bank_r <= held_bank_nxt;
      held_len_r  <= held_len_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (has_result) begin
      s1_kind_r   <= rd ? KIND_READ : KIND_REPORT;
      s1_status_r <= rd ? ST_OK : status;
      s1_type_r   <= (!rd && status == ST_OK) ? ftype_nxt : 16'h0000;
      s1_len_r    <= rd ? 9'd0 : 9'(close_len);
      s1_idx_ok_r <= rd && idx_ok;
    end
    if (s1_advance) begin
      out_item_r.result_kind   <= s1_kind_r;
      out_item_r.check_status  <= s1_status_r;
      out_item_r.record_type   <= s1_type_r;
      out_item_r.record_length <= s1_len_r;
      out_item_r.read_byte     <= s1_idx_ok_r ? ram_rdata : 8'h00;
      out_item_r.index_valid   <= s1_idx_ok_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[tb/rdc_tb_pkg.sv]
// Scoreboard class and CRC helper for the record deframer and checker testbench.
`timescale 1ns / 1ps

package rdc_tb_pkg;

  import rdc_pkg::*;

  // One byte into a reflected CRC-16/ARC accumulator, one input bit at a time.
  function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    int k;
    c = acc;
    for (k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  class deframe_scoreboard;

    logic [7:0]  start_m;
    logic [7:0]  end_m;
    logic [7:0]  esc_m;
    logic [7:0]  esc_off;

    bit          in_rec;
    bit          esc_pend;
    logic [7:0]  build_mem [RECORD_BYTES];
    logic [7:0]  held_mem [RECORD_BYTES];
    int          fill;
    int          held_len;
    logic [15:0] crc;
    logic [15:0] st_len;
    logic [15:0] st_crc;
    logic [15:0] ftype;

    out_item_t   owed [$];
    int          errors;

    function new();
      start_m  = RST_START;
      end_m    = RST_END;
      esc_m    = RST_ESC;
      esc_off  = RST_ESC_OFFSET;
      in_rec   = 1'b0;
      esc_pend = 1'b0;
      fill     = 0;
      held_len = 0;
      crc      = '0;
      st_len   = '0;
      st_crc   = '0;
      ftype    = '0;
      errors   = 0;
    endfunction

    function void write_reg(input logic [7:0] idx, input logic [7:0] data);
      case (idx)
        CFG_START:      start_m = data;
        CFG_END:        end_m   = data;
        CFG_ESC:        esc_m   = data;
        CFG_ESC_OFFSET: esc_off = data;
        default: ;
      endcase
    endfunction

    function void append(input logic [7:0] b);
      build_mem[fill] = b;
      case (fill)
        1: st_len[7:0]  = b;
        2: st_len[15:8] = b;
        3: st_crc[7:0]  = b;
        4: st_crc[15:8] = b;
        5: ftype[7:0]   = b;
        6: ftype[15:8]  = b;
        default: ;
      endcase
      crc  = crc_fold(crc, (fill == 3 || fill == 4) ? 8'h00 : b);
      fill = fill + 1;
    endfunction

    function void open_rec();
      fill     = 0;
      crc      = '0;
      st_len   = '0;
      st_crc   = '0;
      ftype    = '0;
      esc_pend = 1'b0;
      append(start_m);
    endfunction

    function void drop();
      in_rec   = 1'b0;
      esc_pend = 1'b0;
      fill     = 0;
    endfunction

    // Advance the model by one accepted item and queue the result it owes.
    function void absorb_item(input in_item_t it);
      out_item_t  res;
      logic [1:0] verdict;
      logic [7:0] b;
      int         i;
      b = it.rx_byte;
      if (it.opcode == OP_READ) begin
        res = '0;
        res.result_kind = KIND_READ;
        if (int'(it.read_index) < held_len) begin
          res.read_byte   = held_mem[it.read_index];
          res.index_valid = 1'b1;
        end
        owed.push_back(res);
        return;
      end
      if (!in_rec) begin
        if (b == start_m) begin
          in_rec = 1'b1;
          open_rec();
        end
        return;
      end
      if (esc_pend) begin
        esc_pend = 1'b0;
        if (fill < RECORD_BYTES) begin
          append(b - esc_off);
        end else begin
          drop();
        end
        return;
      end
      if (b == esc_m) begin
        esc_pend = 1'b1;
        return;
      end
      if (b == start_m) begin
        open_rec();
        return;
      end
      if (fill >= RECORD_BYTES) begin
        drop();
        return;
      end
      append(b);
      if (b != end_m) return;

      for (i = 0; i < fill; i++) held_mem[i] = build_mem[i];
      held_len = fill;
      drop();

      if (held_len < MIN_RECORD) begin
        verdict = ST_SHORT;
      end else if (int'(st_len) != held_len) begin
        verdict = ST_LEN_BAD;
      end else if (crc != st_crc) begin
        verdict = ST_CRC_BAD;
      end else begin
        verdict = ST_OK;
      end
      res = '0;
      res.result_kind   = KIND_REPORT;
      res.check_status  = verdict;
      res.record_type   = (verdict == ST_OK) ? ftype : 16'h0000;
      res.record_length = 9'(held_len);
      owed.push_back(res);
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 40) $display("%0t mismatch: %s", $time, msg);
    endtask

    task compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_result(input out_item_t got);
      out_item_t want;
      if (owed.size() == 0) begin
        report($sformatf("result %h with nothing owed", got));
        return;
      end
      want = owed.pop_front();
      compare_field("result_kind",   16'(got.result_kind),   16'(want.result_kind));
      compare_field("check_status",  16'(got.check_status),  16'(want.check_status));
      compare_field("record_type",   got.record_type,        want.record_type);
      compare_field("record_length", 16'(got.record_length), 16'(want.record_length));
      compare_field("read_byte",     16'(got.read_byte),     16'(want.read_byte));
      compare_field("index_valid",   16'(got.index_valid),   16'(want.index_valid));
    endtask

  endclass

endpackage

[tb/record_deframer_checker_tb.sv]
// Testbench top: random framed byte streams and reads against a scoreboard of the deframer.
`timescale 1ns / 1ps

module record_deframer_checker_tb;

  import rdc_pkg::*;
  import rdc_tb_pkg::*;

  // Far above the slowest clean run: every item behind a gap, the registered
  // result path and a long stall burst on the result side.
  localparam int LIMIT_CYCLES = 400000;
  // Idle cycles before a register write and at the end; covers the result path.
  localparam int SETTLE = 6;

  typedef enum int {REC_GOOD, REC_BAD_CRC, REC_BAD_LEN, REC_SHORT} rec_kind_e;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;

  deframe_scoreboard sb;
  int                cycle_count = 0;
  int                fed_items   = 0;
  bit                quiet_link  = 1'b0;   // no gaps and no stalls while set
  logic [7:0]        rec_bytes [$];        // unescaped record being built

  record_deframer_checker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Result side: take what the edge accepted, then pick the stall for the next edge.
  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_stall === 1'b0) sb.check_result(out_item);
    out_stall <= !quiet_link && ($urandom_range(99) < 12);
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("record_deframer_checker_tb: errors");
    $finish;
  end

  // Offer one item, hold it until the block takes it, then note it in the model.
  task automatic send_item(input in_item_t it);
    if (!quiet_link && $urandom_range(99) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.absorb_item(it);
  endtask

  // Feed one raw byte; counted only when it belongs to built traffic.
  task automatic send_byte(input logic [7:0] b, input bit counted);
    in_item_t it;
    it.opcode     = OP_FEED;
    it.rx_byte    = b;
    it.read_index = 8'($urandom_range(255));
    send_item(it);
    if (counted) fed_items++;
  endtask

  // Read one held byte; a negative index picks one, mostly inside the held record.
  task automatic send_read(input int idx);
    in_item_t it;
    it.opcode  = OP_READ;
    it.rx_byte = 8'($urandom_range(255));
    if (idx >= 0) begin
      it.read_index = 8'(idx);
    end else if (sb.held_len > 0 && $urandom_range(3) != 0) begin
      it.read_index = 8'($urandom_range(sb.held_len - 1));
    end else begin
      it.read_index = 8'($urandom_range(255));
    end
    send_item(it);
    fed_items++;
  endtask

  // Fill in the stated length and the CRC, except for a short record; a bad length or CRC kind spoils one of them.
  task automatic seal_record(input rec_kind_e kind);
    logic [15:0] acc;
    logic [15:0] len;
    int          n;
    int          i;
    n = rec_bytes.size();
    if (kind == REC_SHORT || n < MIN_RECORD) return;
    len = (kind == REC_BAD_LEN) ? 16'(n + $urandom_range(1, 300)) : 16'(n);
    rec_bytes[1] = len[7:0];
    rec_bytes[2] = len[15:8];
    acc = '0;
    for (i = 0; i < n; i++) acc = crc_fold(acc, (i == 3 || i == 4) ? 8'h00 : rec_bytes[i]);
    if (kind == REC_BAD_CRC) acc = acc ^ 16'($urandom_range(1, 65535));
    rec_bytes[3] = acc[7:0];
    rec_bytes[4] = acc[15:8];
  endtask

  task automatic build_record(input int n, input rec_kind_e kind);
    int i;
    rec_bytes.delete();
    rec_bytes.push_back(sb.start_m);
    for (i = 1; i < n - 1; i++) rec_bytes.push_back(8'($urandom_range(255)));
    rec_bytes.push_back(sb.end_m);
    seal_record(kind);
  endtask

  // Send the first upto bytes of the record. Escape every inner byte that
  // collides with a marker, force one at esc_at, escape a few at random and slip in reads.
  task automatic send_record(input int upto, input int esc_at);
    logic [7:0] b;
    int         i;
    for (i = 0; i < upto; i++) begin
      b = rec_bytes[i];
      if ($urandom_range(99) < 6) send_read(-1);
      if (i == 0 || i == rec_bytes.size() - 1) begin
        send_byte(b, 1'b1);
      end else if (b == sb.start_m || b == sb.end_m || b == sb.esc_m || i == esc_at ||
                   $urandom_range(9) == 0) begin
        send_byte(sb.esc_m, 1'b1);
        send_byte(b + sb.esc_off, 1'b1);
      end else begin
        send_byte(b, 1'b1);
      end
    end
  endtask

  // Stop offering items and wait for every owed result, plus the path latency.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Leave a record open so the next marker set takes over mid-record.
  task automatic leave_open();
    build_record(12, REC_GOOD);
    send_record($urandom_range(1, 6), -1);
  endtask

  // Write all four markers; optionally slip in a write to an unused index.
  task automatic load_markers(input logic [7:0] s, input logic [7:0] e, input logic [7:0] x,
                              input logic [7:0] o, input bit stray);
    logic [7:0] idx_q [$];
    logic [7:0] dat_q [$];
    int         i;
    idx_q.push_back(CFG_START);      dat_q.push_back(s);
    idx_q.push_back(CFG_END);        dat_q.push_back(e);
    if (stray) begin
      idx_q.push_back(CFG_ESC_OFFSET + 8'($urandom_range(1, 252)));
      dat_q.push_back(8'($urandom_range(255)));
    end
    idx_q.push_back(CFG_ESC);        dat_q.push_back(x);
    idx_q.push_back(CFG_ESC_OFFSET); dat_q.push_back(o);
    // Keep cfg_valid high across back-to-back writes; drop it once at the end.
    for (i = 0; i < idx_q.size(); i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_q[i];
      cfg_data  <= dat_q[i];
      @(posedge clk);
      while (cfg_ready !== 1'b1) @(posedge clk);
      sb.write_reg(idx_q[i], dat_q[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed records with random content, the rest damaged, cut short, overlong, noise, reads or drains.
  task automatic random_phase(input int quota);
    int pick;
    int n;
    fed_items = 0;
    while (fed_items < quota) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
      end else if (pick < 9) begin
        build_record($urandom_range(2, MIN_RECORD - 1), REC_SHORT);
        send_record(rec_bytes.size(), -1);
      end else if (pick < 15) begin
        build_record($urandom_range(MIN_RECORD, 40), REC_BAD_CRC);
        send_record(rec_bytes.size(), -1);
      end else if (pick < 21) begin
        build_record($urandom_range(MIN_RECORD, 40), REC_BAD_LEN);
        send_record(rec_bytes.size(), -1);
      end else if (pick < 25) begin
        // Cut short; the next start byte restarts the record.
        n = $urandom_range(MIN_RECORD, 40);
        build_record(n, REC_GOOD);
        send_record($urandom_range(1, n - 1), -1);
      end else if (pick < 27) begin
        n = $urandom_range(1) ? $urandom_range(RECORD_BYTES + 1, RECORD_BYTES + 4)
                              : $urandom_range(200, RECORD_BYTES);
        build_record(n, REC_GOOD);
        send_record(n, (n > RECORD_BYTES && $urandom_range(1)) ? RECORD_BYTES : -1);
      end else if (pick < 32) begin
        repeat ($urandom_range(1, 4)) send_read(-1);
      end else if (pick < 33) begin
        drain();
      end else begin
        build_record($urandom_range(MIN_RECORD, 40), REC_GOOD);
        send_record(rec_bytes.size(), -1);
      end
    end
  endtask

  initial begin
    logic [7:0] s;
    logic [7:0] e;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reads with nothing held, noise while hunting, a two-byte
    // record, a record carrying escaped markers, reads in and past range.
    send_read(0);
    send_read(255);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(RST_ESC, 1'b0);
    send_byte(RST_END, 1'b0);
    build_record(2, REC_SHORT);
    send_record(rec_bytes.size(), -1);
    build_record(9, REC_GOOD);
    rec_bytes[5] = sb.end_m;
    rec_bytes[6] = sb.start_m;
    rec_bytes[7] = sb.esc_m;
    seal_record(REC_GOOD);
    send_record(rec_bytes.size(), -1);
    send_read(0);
    send_read(8);
    send_read(9);

    random_phase(170);
    leave_open();
    drain();

    // Extreme markers, zero offset, no idling on either side.
    load_markers(8'h00, 8'hFF, 8'h01, 8'h00, 1'b0);
    quiet_link = 1'b1;
    build_record(RECORD_BYTES, REC_GOOD);
    send_record(RECORD_BYTES, -1);
    send_read(RECORD_BYTES - 1);
    // Overflow on an escaped byte, then on a plain end byte; the held record stays.
    build_record(RECORD_BYTES + 2, REC_GOOD);
    send_record(rec_bytes.size(), RECORD_BYTES);
    send_read(0);
    build_record(RECORD_BYTES + 1, REC_GOOD);
    send_record(rec_bytes.size(), -1);
    send_read(RECORD_BYTES - 1);
    random_phase(140);
    quiet_link = 1'b0;
    leave_open();
    drain();

    load_markers(8'hFF, 8'h00, 8'hFE, 8'hFF, 1'b0);
    random_phase(170);
    leave_open();
    drain();

    s = $urandom_range(255);
    e = s + 8'($urandom_range(1, 85));
    load_markers(s, e, e + 8'($urandom_range(1, 85)), 8'($urandom_range(255)), 1'b1);
    random_phase(170);
    leave_open();
    drain();

    // Start and escape share a value: inside a record that byte only escapes.
    load_markers(8'h05, 8'h06, 8'h05, 8'($urandom_range(255)), 1'b0);
    random_phase(80);
    drain();

    load_markers(RST_START, RST_END, RST_ESC, RST_ESC_OFFSET, 1'b1);
    random_phase(120);
    drain();

    if (sb.errors == 0) begin
      $display("record_deframer_checker_tb: clean");
    end else begin
      $display("record_deframer_checker_tb: errors");
    end
    $finish;
  end

endmodule
